[src/bira_pkg.sv]
// Shared types and constants for the bounded insert/remove array unit.
package bira_pkg;

   localparam int CAPACITY = 64;
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int POS_W    = 7;
   localparam int COUNT_W  = 7;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = $clog2(CAPACITY + 1);
   // Width used for every index compare, wide enough for a request position and for the length.
   localparam int CMP_W    = (FILL_W > POS_W) ? FILL_W : POS_W;
   localparam int GROUP    = 8;
   localparam int NGROUPS  = (CAPACITY + GROUP - 1) / GROUP;

   typedef enum logic [OP_W-1:0] {
      OP_READ   = 3'd0,
      OP_WRITE  = 3'd1,
      OP_INSERT = 3'd2,
      OP_REMOVE = 3'd3,
      OP_RESIZE = 3'd4,
      OP_ERASE  = 3'd5
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_RANGE  = 2'd1,
      ST_LENGTH = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_READ,
      CMD_WRITE,
      CMD_INSERT,
      CMD_REMOVE,
      CMD_TRUNC,
      CMD_ERASE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [CMP_W-1:0]  pos;
      logic [CMP_W-1:0]  bound;
      logic [DATA_W-1:0] data;
   } cmd_type;

endpackage

[src/bira_cell.sv]
// One storage cell of the shifting chain.
module bira_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic [bira_pkg::CMP_W-1:0] idx,
   input  bira_pkg::cmd_type          cmd,
   input  logic [bira_pkg::DATA_W-1:0] left_data,
   input  logic [bira_pkg::DATA_W-1:0] right_data,
   output logic [bira_pkg::DATA_W-1:0] data_out,
   output logic [bira_pkg::DATA_W-1:0] rd_out
);

   logic [bira_pkg::DATA_W-1:0] data_ff;
   logic [bira_pkg::DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      case (cmd.kind)
         bira_pkg::CMD_WRITE: begin
            if (idx == cmd.pos) data_in = cmd.data;
         end
         bira_pkg::CMD_INSERT: begin
            if (idx == cmd.pos) data_in = cmd.data;
            else if (idx > cmd.pos) data_in = left_data;
         end
         bira_pkg::CMD_REMOVE: begin
            if (idx >= cmd.pos) data_in = right_data;
         end
         bira_pkg::CMD_TRUNC: begin
            if (idx >= cmd.bound) data_in = '0;
         end
         bira_pkg::CMD_ERASE: begin
            data_in = '0;
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         data_ff <= '0;
      end else if (en) begin
         data_ff <= data_in;
      end
   end

   assign data_out = data_ff;
   assign rd_out   = (cmd.kind == bira_pkg::CMD_READ && idx == cmd.pos) ? data_ff : '0;

endmodule

[src/bira_ctrl.sv]
// Length register, range checks and the command broadcast to the cell chain.
module bira_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic [bira_pkg::OP_W-1:0]     op,
   input  logic [bira_pkg::POS_W-1:0]    position,
   input  logic [bira_pkg::DATA_W-1:0]   data_in,
   input  logic [bira_pkg::POS_W-1:0]    new_size,
   output bira_pkg::cmd_type             cmd,
   output logic [bira_pkg::STATUS_W-1:0] status,
   output logic [bira_pkg::COUNT_W-1:0]  count
);

   logic [bira_pkg::FILL_W-1:0] fill_ff;
   logic [bira_pkg::FILL_W-1:0] fill_in;
   logic [bira_pkg::CMP_W-1:0]  pos_c;
   logic [bira_pkg::CMP_W-1:0]  want_c;
   logic [bira_pkg::CMP_W-1:0]  fill_c;
   logic [bira_pkg::CMP_W-1:0]  cap_c;
   logic [bira_pkg::CMP_W-1:0]  fill_next_c;

   assign pos_c  = bira_pkg::CMP_W'(position);
   assign want_c = bira_pkg::CMP_W'(new_size);
   assign fill_c = bira_pkg::CMP_W'(fill_ff);
   assign cap_c  = bira_pkg::CMP_W'(bira_pkg::CAPACITY);

   always_comb begin
      fill_in   = fill_ff;
      status    = bira_pkg::ST_OK;
      cmd.kind  = bira_pkg::CMD_NONE;
      cmd.pos   = pos_c;
      cmd.bound = want_c;
      cmd.data  = data_in;
      case (op)
         bira_pkg::OP_READ: begin
            if (pos_c < fill_c) cmd.kind = bira_pkg::CMD_READ;
            else status = bira_pkg::ST_RANGE;
         end
         bira_pkg::OP_WRITE: begin
            if (pos_c < fill_c) cmd.kind = bira_pkg::CMD_WRITE;
            else status = bira_pkg::ST_RANGE;
         end
         bira_pkg::OP_INSERT: begin
            if (pos_c > fill_c) begin
               status = bira_pkg::ST_RANGE;
            end else if (fill_c >= cap_c) begin
               status = bira_pkg::ST_FULL;
            end else begin
               cmd.kind = bira_pkg::CMD_INSERT;
               fill_in  = bira_pkg::FILL_W'(fill_ff + 1'b1);
            end
         end
         bira_pkg::OP_REMOVE: begin
            if (pos_c >= fill_c) begin
               status = bira_pkg::ST_RANGE;
            end else begin
               cmd.kind = bira_pkg::CMD_REMOVE;
               fill_in  = bira_pkg::FILL_W'(fill_ff - 1'b1);
            end
         end
         bira_pkg::OP_RESIZE: begin
            if (want_c > cap_c) begin
               status = bira_pkg::ST_LENGTH;
            end else begin
               cmd.kind = bira_pkg::CMD_TRUNC;
               fill_in  = bira_pkg::FILL_W'(want_c);
            end
         end
         bira_pkg::OP_ERASE: begin
            cmd.kind = bira_pkg::CMD_ERASE;
            fill_in  = '0;
         end
         default: begin
            fill_in = fill_ff;
         end
      endcase
   end

   // The reported count is the new length, kept to its low seven bits.
   assign fill_next_c = bira_pkg::CMP_W'(fill_in);
   assign count       = fill_next_c[bira_pkg::COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (en) begin
         fill_ff <= fill_in;
      end
   end

endmodule

[src/bounded_insert_remove_array_unit.sv]
// Top level of the bounded insert/remove array unit.
//
// This unit keeps an ordered array of up to CAPACITY signed 32-bit words in a row of
// cells, and each request reads, writes, inserts before, removes at, resizes or erases it.
// All cells act together in the same cycle: on an insert every cell above the position takes its
// lower neighbor's word, on a remove every cell at or above it takes its upper neighbor's
// word, so one request is taken every cycle whatever the command unless the pipe is held
// back. A request passes three registers on its way: the request register, where the cells
// are updated and the read data is gathered into groups of eight, the group register, and
// the response register, where its response shows on the rsp_ ports until it is taken.
// The response register parts the two sides; a stalled response holds the pipe back only
// once every stage is full. The array and its length are cleared by reset.
module bounded_insert_remove_array_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [bira_pkg::OP_W-1:0]            req_op,
   input  logic [bira_pkg::POS_W-1:0]           req_position,
   input  logic signed [bira_pkg::DATA_W-1:0]   req_data_in,
   input  logic [bira_pkg::POS_W-1:0]           req_new_size,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bira_pkg::DATA_W-1:0]   rsp_read_data,
   output logic [bira_pkg::STATUS_W-1:0]        rsp_status,
   output logic [bira_pkg::COUNT_W-1:0]         rsp_count
);

   // Request stage.
   logic                          s1_valid_ff;
   logic [bira_pkg::OP_W-1:0]     s1_op_ff;
   logic [bira_pkg::POS_W-1:0]    s1_pos_ff;
   logic [bira_pkg::DATA_W-1:0]   s1_din_ff;
   logic [bira_pkg::POS_W-1:0]    s1_want_ff;

   // Group stage.
   logic                          s2_valid_ff;
   logic [bira_pkg::STATUS_W-1:0] s2_status_ff;
   logic [bira_pkg::COUNT_W-1:0]  s2_count_ff;
   logic [bira_pkg::DATA_W-1:0]   grp_ff [bira_pkg::NGROUPS];
   logic [bira_pkg::DATA_W-1:0]   grp_in [bira_pkg::NGROUPS];

   // Response stage.
   logic                          rsp_valid_ff;
   logic [bira_pkg::DATA_W-1:0]   rsp_data_ff;
   logic [bira_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [bira_pkg::COUNT_W-1:0]  rsp_count_ff;
   logic [bira_pkg::DATA_W-1:0]   rsp_data_in;

   logic s1_adv;
   logic s2_adv;
   logic exec;

   bira_pkg::cmd_type             cmd;
   logic [bira_pkg::STATUS_W-1:0] status;
   logic [bira_pkg::COUNT_W-1:0]  count;

   logic [bira_pkg::DATA_W-1:0] cell_data [bira_pkg::CAPACITY];
   logic [bira_pkg::DATA_W-1:0] cell_rd   [bira_pkg::CAPACITY];

   // A stage moves on when the stage after it is empty or moving on itself.
   assign s2_adv    = !rsp_valid_ff || !rsp_stall;
   assign s1_adv    = !s2_valid_ff || s2_adv;
   assign req_stall = s1_valid_ff && !s1_adv;
   assign exec      = s1_valid_ff && s1_adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         s1_op_ff   <= req_op;
         s1_pos_ff  <= req_position;
         s1_din_ff  <= req_data_in;
         s1_want_ff <= req_new_size;
      end
   end

   bira_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .en       (exec),
      .op       (s1_op_ff),
      .position (s1_pos_ff),
      .data_in  (s1_din_ff),
      .new_size (s1_want_ff),
      .cmd      (cmd),
      .status   (status),
      .count    (count)
   );

   // The chain: each cell sees its neighbors' words, the ends see zero.
   for (genvar i = 0; i < bira_pkg::CAPACITY; i++) begin : g_cell
      logic [bira_pkg::DATA_W-1:0] left_w;
      logic [bira_pkg::DATA_W-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = '0;
      end else begin : g_inner_l
         assign left_w = cell_data[i-1];
      end

      if (i == bira_pkg::CAPACITY - 1) begin : g_last
         assign right_w = '0;
      end else begin : g_inner_r
         assign right_w = cell_data[i+1];
      end

      bira_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (exec),
         .idx        (bira_pkg::CMP_W'(i)),
         .cmd        (cmd),
         .left_data  (left_w),
         .right_data (right_w),
         .data_out   (cell_data[i]),
         .rd_out     (cell_rd[i])
      );
   end

   // Only the addressed cell of a good read drives a nonzero word, so the read is an OR
   // over the cells, gathered eight at a time before the group register.
   always_comb begin
      for (int g = 0; g < bira_pkg::NGROUPS; g++) begin
         grp_in[g] = '0;
         for (int k = 0; k < bira_pkg::GROUP; k++) begin
            if (g * bira_pkg::GROUP + k < bira_pkg::CAPACITY) begin
               grp_in[g] = grp_in[g] | cell_rd[g * bira_pkg::GROUP + k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (exec) begin
         s2_status_ff <= status;
         s2_count_ff  <= count;
         for (int g = 0; g < bira_pkg::NGROUPS; g++) begin
            grp_ff[g] <= grp_in[g];
         end
      end
   end

   always_comb begin
      rsp_data_in = '0;
      for (int g = 0; g < bira_pkg::NGROUPS; g++) begin
         rsp_data_in = rsp_data_in | grp_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv && s2_valid_ff) begin
         rsp_data_ff   <= rsp_data_in;
         rsp_status_ff <= s2_status_ff;
         rsp_count_ff  <= s2_count_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_count     = rsp_count_ff;

endmodule

[src/bira_checker.sv]
// Port-level assertions for the bounded insert/remove array unit, bound to the top level.
module bira_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_stall,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [bira_pkg::DATA_W-1:0]   rsp_read_data,
   input logic [bira_pkg::STATUS_W-1:0]        rsp_status,
   input logic [bira_pkg::COUNT_W-1:0]         rsp_count
);

   localparam logic [bira_pkg::CMP_W-1:0] CAP_C = bira_pkg::CMP_W'(bira_pkg::CAPACITY);
   localparam logic [bira_pkg::COUNT_W-1:0] CAP_COUNT = CAP_C[bira_pkg::COUNT_W-1:0];

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data)
         && $stable(rsp_status) && $stable(rsp_count))
      else $error("stalled response changed");

   // Any failed request returns zero read data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bira_pkg::ST_OK |-> rsp_read_data == '0)
      else $error("failed request returned data");

   // A full report only comes when the length is at capacity.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == bira_pkg::ST_FULL |-> rsp_count == CAP_COUNT)
      else $error("full status with length below capacity");

   // The input is only held off while a response waits on a stalled receiver.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled with the response side free");

   // Reset empties the response register.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("response present right after reset");

endmodule

bind bounded_insert_remove_array_unit bira_checker u_bira_checker (.*);
